/* rtl/assert_macros.svh */
// Assertion macros for the checker of the tank refill sequencer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TRP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trp assertion failed");

// Clocked assertion that is also checked during reset.
`define TRP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("trp assertion failed");

`endif

/* rtl/trp_pkg.sv */
// Package of the tank refill pump sequencer: item types, codes and constants.
// Depends on nothing; imported by every module of the block.
package trp_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PUMP_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PUMP_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_QUALIFY  = 2'd2;

    localparam logic [CFG_W-1:0] PUMP_ON_RESET  = 16'd6000;
    localparam logic [CFG_W-1:0] PUMP_OFF_RESET = 16'd30000;
    localparam logic [CFG_W-1:0] QUALIFY_RESET  = 16'd1000;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PUMP  = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;

    typedef struct packed {
        logic not_empty_switch;
        logic full_switch;
        logic voltage_ok;
        logic tank_enable;
    } t_in_item;

    typedef struct packed {
        logic       circulate;
        logic       replenish;
        logic [1:0] phase;
    } t_out_item;

    typedef struct packed {
        logic full_on;
        logic full_off;
    } t_full_flags;

    // Limits a register value to what a timer counter can hold.
    function automatic logic [TIMER_BITS-1:0] clip_preset(input logic [CFG_W-1:0] p);
        logic [32:0] wide;
        logic [32:0] lim;
        wide = 33'(p);
        lim  = (33'(1) << TIMER_BITS) - 33'd1;
        return (wide > lim) ? lim[TIMER_BITS-1:0] : wide[TIMER_BITS-1:0];
    endfunction

endpackage

/* rtl/tank_refill_pump_sequencer_core.sv */
// Top level of the tank refill pump sequencer: configuration registers and result register.
// Depends on trp_pkg, trp_full_filter and trp_seq.
//
// Usage: every input item is one 10 ms tick with the level switches, the
// voltage status and the enable bit. An item is taken when i_in_valid is high
// and o_in_stall is low; its result item appears on o_out_data with
// o_out_valid in the next cycle and leaves when i_out_stall is low.
// One item per cycle unless o_in_stall is high: the filters, the pump timer and the phase
// logic all update in the cycle of acceptance, in front of the result register.
// When the receiver stalls, the held result stays put and o_in_stall rises only
// while that result still waits, so no item is lost.
// The configuration port takes a write in every cycle (o_cfg_ready is always
// high); index 0 sets the pump run time, 1 the pause time, 2 the qualify time,
// and other indexes are ignored. Write it only while no item is in flight.
// Synchronous reset clears the timers and the phase to idle, loads the default
// register values and empties the result register.
module tank_refill_pump_sequencer_core
    import trp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_pump_on, r_pump_off, r_qualify;
    logic             r_out_valid;
    t_out_item        r_out_data, n_out_data;
    logic             w_accept;
    logic             w_ok;
    t_full_flags      w_flags;
    logic [1:0]       w_phase;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_ok        = i_in_data.voltage_ok && i_in_data.tank_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_on  <= PUMP_ON_RESET;
            r_pump_off <= PUMP_OFF_RESET;
            r_qualify  <= QUALIFY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_PUMP_ON:  r_pump_on  <= i_cfg_data;
                CFG_IDX_PUMP_OFF: r_pump_off <= i_cfg_data;
                CFG_IDX_QUALIFY:  r_qualify  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    trp_full_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_accept),
        .i_full   (i_in_data.full_switch),
        .i_preset (clip_preset(r_qualify)),
        .o_flags  (w_flags)
    );

    trp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_accept),
        .i_ok         (w_ok),
        .i_flags      (w_flags),
        .i_on_preset  (clip_preset(r_pump_on)),
        .i_off_preset (clip_preset(r_pump_off)),
        .o_phase      (w_phase)
    );

    always_comb begin
        n_out_data.circulate = i_in_data.not_empty_switch && w_ok;
        n_out_data.replenish = (w_phase == PH_PUMP);
        n_out_data.phase     = w_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/trp_full_filter.sv */
// On-delay and off-delay filters of the full level switch.
// Depends on trp_pkg for the timer width and the flag struct.
module trp_full_filter
    import trp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  logic                  i_full,
    input  logic [TIMER_BITS-1:0] i_preset,
    output t_full_flags           o_flags
);

    logic [TIMER_BITS-1:0] r_on_count, n_on_count;
    logic [TIMER_BITS-1:0] r_off_count, n_off_count;
    logic                  r_full_seen, n_full_seen;

    always_comb begin
        // On-delay: counts while full, clears when not full.
        if (!i_full) begin
            n_on_count = '0;
        end else if (r_on_count < i_preset) begin
            n_on_count = r_on_count + TIMER_BITS'(1);
        end else begin
            n_on_count = r_on_count;
        end

        // Off-delay: output follows a high input at once and drops late.
        n_off_count = r_off_count;
        n_full_seen = r_full_seen;
        if (i_full) begin
            n_full_seen = 1'b1;
            n_off_count = '0;
        end else if (r_full_seen) begin
            if (r_off_count < i_preset) begin
                n_off_count = r_off_count + TIMER_BITS'(1);
            end
            if (n_off_count >= i_preset) begin
                n_full_seen = 1'b0;
            end
        end

        o_flags.full_on  = i_full && (n_on_count >= i_preset);
        o_flags.full_off = n_full_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_count  <= '0;
            r_off_count <= '0;
            r_full_seen <= 1'b0;
        end else if (i_tick) begin
            r_on_count  <= n_on_count;
            r_off_count <= n_off_count;
            r_full_seen <= n_full_seen;
        end
    end

endmodule

/* rtl/trp_seq.sv */
// Refill sequencer: pump timer and idle, pumping and pause phases.
// Depends on trp_pkg for phase codes, the timer width and the flag struct.
module trp_seq
    import trp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  logic                  i_ok,
    input  t_full_flags           i_flags,
    input  logic [TIMER_BITS-1:0] i_on_preset,
    input  logic [TIMER_BITS-1:0] i_off_preset,
    output logic [1:0]            o_phase
);

    logic [1:0]            r_phase, n_phase;
    logic                  r_run, n_run;
    logic                  r_use_off, n_use_off;
    logic [TIMER_BITS-1:0] r_count, n_count;
    logic [TIMER_BITS-1:0] w_preset;
    logic                  w_done;

    always_comb begin
        // The timer runs on the run bit left by the previous item.
        w_preset = r_use_off ? i_off_preset : i_on_preset;
        if (!r_run) begin
            n_count = '0;
        end else if (r_count < w_preset) begin
            n_count = r_count + TIMER_BITS'(1);
        end else begin
            n_count = r_count;
        end
        w_done = r_run && (n_count >= w_preset);

        n_phase   = i_ok ? r_phase : PH_IDLE;
        n_run     = i_ok && r_run;
        n_use_off = r_use_off;

        case (n_phase)
            PH_PUMP: begin
                if (w_done) begin
                    n_run   = 1'b0;
                    n_phase = PH_PAUSE;
                end else if (i_flags.full_on) begin
                    n_run   = 1'b0;
                    n_phase = PH_IDLE;
                end
            end
            PH_PAUSE: begin
                if (w_done) begin
                    n_run   = 1'b0;
                    n_phase = PH_IDLE;
                end else begin
                    n_run     = 1'b1;
                    n_use_off = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_ok && !i_flags.full_off) begin
                    n_run     = 1'b1;
                    n_use_off = 1'b0;
                    n_phase   = PH_PUMP;
                end
            end
        endcase

        o_phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_run     <= 1'b0;
            r_use_off <= 1'b0;
            r_count   <= '0;
        end else if (i_tick) begin
            r_phase   <= n_phase;
            r_run     <= n_run;
            r_use_off <= n_use_off;
            r_count   <= n_count;
        end
    end

endmodule

/* rtl/trp_checker.sv */
// Port-level checker of the tank refill pump sequencer, bound to the top level.
// Depends on trp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trp_checker
    import trp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic w_in_acc;
    logic w_circ;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_circ   = i_in_data.not_empty_switch && i_in_data.voltage_ok
                      && i_in_data.tank_enable;

    // The refill pump runs exactly in the pumping phase.
    `TRP_ASSERT(a_replenish_phase, i_clk, i_rst_n, o_out_valid |-> (o_out_data.replenish == (o_out_data.phase == PH_PUMP)))

    // An accepted item shows its circulation result in the next cycle.
    `TRP_ASSERT(a_circulate, i_clk, i_rst_n, w_in_acc |=> (o_out_valid && (o_out_data.circulate == $past(w_circ))))

    // An item without voltage forces the idle phase.
    `TRP_ASSERT(a_volt_idle, i_clk, i_rst_n, (w_in_acc && !i_in_data.voltage_ok) |=> (o_out_data.phase == PH_IDLE))

    // A stalled result item holds.
    `TRP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))

endmodule

bind tank_refill_pump_sequencer_core trp_checker u_trp_checker (.*);
